/* rtl/binomial_barrier_option_pricer_macros.svh */
// Assertion macros shared by the checker of the binomial barrier pricer.
// Depends on nothing; the checker file includes this header.
`ifndef BINOMIAL_BARRIER_OPTION_PRICER_MACROS_SVH
`define BINOMIAL_BARRIER_OPTION_PRICER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBOP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BBOP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/bbop_pkg.sv */
// Shared types, constants and helper functions of the binomial barrier pricer.
// Depends on nothing; the top level, the multiplier and the checker import it.
package bbop_pkg;

	// Field widths.
	localparam int unsigned DATA_W    = 32;
	localparam int unsigned STEP_W    = 11;
	localparam int unsigned IDX_W     = 3;
	localparam int unsigned PROD_W    = 2 * DATA_W;
	localparam int unsigned S_TDATA_W = 3 * DATA_W;
	localparam int unsigned S_TUSER_W = 2;

	// Default tree depth limit.
	localparam int unsigned MAX_STEPS_DEF = 1024;

	// Q2.30 rounding constant and fraction position.
	localparam int unsigned FRAC_W = 30;
	localparam logic [PROD_W-1:0] Q30_HALF = PROD_W'(64'd536870912);

	// Register reset values.
	localparam logic [DATA_W-1:0] UP_FACTOR_RST   = 32'd1073741824;
	localparam logic [DATA_W-1:0] DOWN_FACTOR_RST = 32'd1073741824;
	localparam logic [DATA_W-1:0] UP_WEIGHT_RST   = 32'd536870912;
	localparam logic [DATA_W-1:0] DOWN_WEIGHT_RST = 32'd536870912;
	localparam logic [STEP_W-1:0] STEP_COUNT_RST  = 11'd1;

	// Configuration register indexes.
	typedef enum logic [IDX_W-1:0] {
		REG_UP_FACTOR   = 3'd0,
		REG_DOWN_FACTOR = 3'd1,
		REG_UP_WEIGHT   = 3'd2,
		REG_DOWN_WEIGHT = 3'd3,
		REG_STEP_COUNT  = 3'd4
	} reg_idx_t;

	// Saturating 32-bit add.
	function automatic logic [DATA_W-1:0] add_sat(input logic [DATA_W-1:0] a,
			input logic [DATA_W-1:0] b);
		logic [DATA_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DATA_W] ? '1 : s[DATA_W-1:0];
	endfunction

	// Node value at a leaf: knocked out, or the call or put payoff.
	function automatic logic [DATA_W-1:0] leaf_value(input logic [DATA_W-1:0] price,
			input logic [DATA_W-1:0] strike, input logic [DATA_W-1:0] barrier,
			input logic put, input logic knock);
		logic [DATA_W-1:0] v;
		if (knock && (price >= barrier)) begin
			v = '0;
		end else if (put) begin
			v = (strike > price) ? (strike - price) : '0;
		end else begin
			v = (price > strike) ? (price - strike) : '0;
		end
		return v;
	endfunction

endpackage

/* rtl/binomial_barrier_option_pricer.sv */
// Channel  Dir  Handshake                Payload
// s_*      in   s_tvalid / s_tready      tdata: spot, strike, barrier; tuser: kind, enable
// m_*      out  m_tvalid / m_tready      tdata: option_value
// cfg_*    in   cfg_valid / cfg_ready    cfg_index, cfg_data
//
// The work per option is set by the single shared multiplier: 3 products per roll-back node,
// 2 per terminal node, issued in a fixed sequence around its registered latency.
// Reset (arst_n low) clears control state and returns the configuration registers to their defaults.
// A new option is taken only while the sequencer is idle; a finished result may still wait
// in the output register, and the sequencer stalls before its next result until it is taken.
module binomial_barrier_option_pricer
	import bbop_pkg::*;
#(
	parameter int unsigned MAX_STEPS = MAX_STEPS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input beat: option to price.
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // [31:0] spot, [63:32] strike, [95:64] barrier
	input  logic [S_TUSER_W-1:0] s_tuser,  // [0] option_kind, [1] barrier_enable
	// Result beat.
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [DATA_W-1:0]    m_tdata,  // [31:0] option_value
	// Configuration writes.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int unsigned DEPTH  = MAX_STEPS + 1;
	localparam int unsigned ADDR_W = $clog2(DEPTH);

	typedef enum logic [18:0] {
		ST_IDLE    = 19'h00001,
		ST_UP_MUL  = 19'h00002,
		ST_UP_WAIT = 19'h00004,
		ST_UP_TAKE = 19'h00008,
		ST_T_WR    = 19'h00010,
		ST_T_M1    = 19'h00020,
		ST_T_W1    = 19'h00040,
		ST_T_M2    = 19'h00080,
		ST_T_W2    = 19'h00100,
		ST_T_TAKE  = 19'h00200,
		ST_B_LOAD  = 19'h00400,
		ST_B_VCUR  = 19'h00800,
		ST_B_RD    = 19'h01000,
		ST_B_M1    = 19'h02000,
		ST_B_M2    = 19'h04000,
		ST_B_M3    = 19'h08000,
		ST_B_M4    = 19'h10000,
		ST_B_WR    = 19'h20000,
		ST_OUT     = 19'h40000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [DATA_W-1:0] up_factor_q;
	logic [DATA_W-1:0] down_factor_q;
	logic [DATA_W-1:0] up_weight_q;
	logic [DATA_W-1:0] down_weight_q;
	logic [STEP_W-1:0] step_count_q;

	// Per-option registers.
	logic [DATA_W-1:0] strike_q;
	logic [DATA_W-1:0] barrier_q;
	logic              put_q;
	logic              knock_q;
	logic [ADDR_W-1:0] n_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ADDR_W-1:0] j_q;
	logic [ADDR_W-1:0] lvl_q;
	logic [DATA_W-1:0] pr_q;
	logic [DATA_W-1:0] vcur_q;
	logic [DATA_W-1:0] vnext_q;
	logic [DATA_W-1:0] newpr_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] final_q;
	logic [DATA_W-1:0] out_q;
	logic              out_valid_q;

	// Datapath wires.
	logic              s_accept;
	logic              out_free;
	logic [ADDR_W-1:0] n_next;
	logic [ADDR_W-1:0] j_inc;
	logic [ADDR_W-1:0] cnt_inc;
	logic [DATA_W-1:0] op_a;
	logic [DATA_W-1:0] op_b;
	logic [DATA_W-1:0] mul_res;
	logic [DATA_W-1:0] leaf_val;
	logic [DATA_W-1:0] back_val;
	logic              wr_en;
	logic [DATA_W-1:0] price_wdata;
	logic [DATA_W-1:0] value_wdata;
	logic [ADDR_W-1:0] value_raddr;
	logic [DATA_W-1:0] price_rdata;
	logic [DATA_W-1:0] value_rdata;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_q;
	assign out_free  = !out_valid_q || m_tready;

	// Step count clamped to the tree depth limit.
	assign n_next = (32'(step_count_q) > 32'(MAX_STEPS)) ? ADDR_W'(MAX_STEPS)
		: ADDR_W'(step_count_q);

	assign j_inc   = ADDR_W'(j_q + 1'b1);
	assign cnt_inc = ADDR_W'(cnt_q + 1'b1);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_factor_q   <= UP_FACTOR_RST;
			down_factor_q <= DOWN_FACTOR_RST;
			up_weight_q   <= UP_WEIGHT_RST;
			down_weight_q <= DOWN_WEIGHT_RST;
			step_count_q  <= STEP_COUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_UP_FACTOR:   up_factor_q   <= cfg_data;
				REG_DOWN_FACTOR: down_factor_q <= cfg_data;
				REG_UP_WEIGHT:   up_weight_q   <= cfg_data;
				REG_DOWN_WEIGHT: down_weight_q <= cfg_data;
				REG_STEP_COUNT:  step_count_q  <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		unique case (state_q)
			ST_UP_MUL: begin
				op_a = pr_q;
				op_b = up_factor_q;
			end
			ST_T_M1: begin
				op_a = pr_q;
				op_b = down_factor_q;
			end
			ST_T_M2: begin
				op_a = mul_res;
				op_b = down_factor_q;
			end
			ST_B_M1: begin
				op_a = price_rdata;
				op_b = down_factor_q;
			end
			ST_B_M2: begin
				op_a = vcur_q;
				op_b = up_weight_q;
			end
			ST_B_M3: begin
				op_a = vnext_q;
				op_b = down_weight_q;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	bbop_mul u_mul (
		.clk    (clk),
		.op_a   (op_a),
		.op_b   (op_b),
		.result (mul_res)
	);

	// Node values: payoff at the leaves, weighted sum on the way back.
	assign leaf_val = leaf_value(pr_q, strike_q, barrier_q, put_q, knock_q);
	assign back_val = (knock_q && (newpr_q >= barrier_q)) ? '0 : add_sat(acc_q, mul_res);

	// Node array ports.
	assign wr_en       = (state_q == ST_T_WR) || (state_q == ST_B_WR);
	assign price_wdata = (state_q == ST_T_WR) ? pr_q : newpr_q;
	assign value_wdata = (state_q == ST_T_WR) ? leaf_val : back_val;
	assign value_raddr = (state_q == ST_B_RD) ? j_inc : j_q;

	bbop_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_price_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (j_q),
		.wr_data (price_wdata),
		.rd_addr (j_q),
		.rd_data (price_rdata)
	);

	bbop_ram #(
		.WIDTH (DATA_W),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (j_q),
		.wr_data (value_wdata),
		.rd_addr (value_raddr),
		.rd_data (value_rdata)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			cnt_q   <= '0;
			j_q     <= '0;
			lvl_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept) begin
						n_q     <= n_next;
						cnt_q   <= '0;
						j_q     <= '0;
						state_q <= (n_next == '0) ? ST_T_WR : ST_UP_MUL;
					end
				end
				ST_UP_MUL:  state_q <= ST_UP_WAIT;
				ST_UP_WAIT: state_q <= ST_UP_TAKE;
				ST_UP_TAKE: begin
					cnt_q   <= cnt_inc;
					state_q <= (cnt_inc == n_q) ? ST_T_WR : ST_UP_MUL;
				end
				ST_T_WR: begin
					if (j_q == n_q) begin
						if (n_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							lvl_q   <= n_q;
							j_q     <= '0;
							state_q <= ST_B_LOAD;
						end
					end else begin
						j_q     <= j_inc;
						state_q <= ST_T_M1;
					end
				end
				ST_T_M1:   state_q <= ST_T_W1;
				ST_T_W1:   state_q <= ST_T_M2;
				ST_T_M2:   state_q <= ST_T_W2;
				ST_T_W2:   state_q <= ST_T_TAKE;
				ST_T_TAKE: state_q <= ST_T_WR;
				ST_B_LOAD: state_q <= ST_B_VCUR;
				ST_B_VCUR: state_q <= ST_B_RD;
				ST_B_RD:   state_q <= ST_B_M1;
				ST_B_M1:   state_q <= ST_B_M2;
				ST_B_M2:   state_q <= ST_B_M3;
				ST_B_M3:   state_q <= ST_B_M4;
				ST_B_M4:   state_q <= ST_B_WR;
				ST_B_WR: begin
					if (j_inc == lvl_q) begin
						if (lvl_q == ADDR_W'(1)) begin
							state_q <= ST_OUT;
						end else begin
							lvl_q   <= ADDR_W'(lvl_q - 1'b1);
							j_q     <= '0;
							state_q <= ST_B_LOAD;
						end
					end else begin
						j_q     <= j_inc;
						state_q <= ST_B_RD;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers of the sequencer.
	always_ff @(posedge clk) begin
		if (s_accept) begin
			pr_q      <= s_tdata[DATA_W-1:0];
			strike_q  <= s_tdata[2*DATA_W-1:DATA_W];
			barrier_q <= s_tdata[3*DATA_W-1:2*DATA_W];
			put_q     <= s_tuser[0];
			knock_q   <= s_tuser[1];
		end
		if ((state_q == ST_UP_TAKE) || (state_q == ST_T_TAKE)) begin
			pr_q <= mul_res;
		end
		if (state_q == ST_B_VCUR) begin
			vcur_q <= value_rdata;
		end
		if (state_q == ST_B_M1) begin
			vnext_q <= value_rdata;
		end
		if (state_q == ST_B_M3) begin
			newpr_q <= mul_res;
		end
		if (state_q == ST_B_M4) begin
			acc_q <= mul_res;
		end
		if (state_q == ST_B_WR) begin
			vcur_q  <= vnext_q;
			final_q <= back_val;
		end
		if (state_q == ST_T_WR) begin
			final_q <= leaf_val;
		end
	end

	// Output register: loaded from the sequencer, drained by the result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_OUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_OUT) && out_free) begin
			out_q <= final_q;
		end
	end

endmodule

/* rtl/bbop_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the node price and node value arrays.
module bbop_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1025,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* rtl/bbop_mul.sv */
// Shared Q16.16 by Q2.30 multiplier with half-up rounding and saturation.
// Depends on bbop_pkg; two register stages, the raw product and the rounded result.
module bbop_mul
	import bbop_pkg::*;
(
	input  logic              clk,
	input  logic [DATA_W-1:0] op_a,
	input  logic [DATA_W-1:0] op_b,
	output logic [DATA_W-1:0] result
);

	logic [PROD_W-1:0]        prod_s1;
	logic [PROD_W-1:0]        rounded;
	logic [PROD_W-FRAC_W-1:0] shifted;

	// Stage one: raw product.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(op_a) * PROD_W'(op_b);
	end

	// Round half up, drop the fraction, clamp to 32 bits.
	assign rounded = prod_s1 + Q30_HALF;
	assign shifted = rounded[PROD_W-1:FRAC_W];

	// Stage two: rounded and saturated result.
	always_ff @(posedge clk) begin
		result <= (|shifted[PROD_W-FRAC_W-1:DATA_W]) ? '1 : shifted[DATA_W-1:0];
	end

endmodule

/* rtl/bbop_checker.sv */
// Port-level checker of the binomial barrier pricer, bound to the top level.
// Depends on bbop_pkg and the assertion macro header.
`include "binomial_barrier_option_pricer_macros.svh"

module bbop_checker
	import bbop_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [DATA_W-1:0]    m_tdata
);

	logic       s_beat;
	logic       m_beat;
	logic [1:0] pending_q;

	assign s_beat = s_tvalid && s_tready;
	assign m_beat = m_tvalid && m_tready;

	// Options taken whose result beat has not gone out yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= 2'(pending_q + {1'b0, s_beat} - {1'b0, m_beat});
		end
	end

	// A waiting result holds still until it is taken.
	`BBOP_ASSERT_NEXT(a_result_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	// Only one option is worked on at a time; at most one more result may wait.
	`BBOP_ASSERT_IMPLY(a_one_in_work, clk, arst_n, s_beat, pending_q <= 2'd1, "too many options in flight")
	// A result never appears without an option behind it.
	`BBOP_ASSERT_IMPLY(a_no_orphan, clk, arst_n, m_tvalid, pending_q != 2'd0, "result without an option")
	// Taking an option makes the block busy on the next cycle.
	`BBOP_ASSERT_NEXT(a_busy_after_take, clk, arst_n, s_beat, !s_tready, "ready right after an option was taken")

endmodule

bind binomial_barrier_option_pricer bbop_checker u_bbop_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
